// ===== src/eacc_pkg.sv =====
package eacc_pkg;

  localparam int unsigned QueueDepthDef = 2;
  localparam int unsigned CfgIdxW = 2;

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] REG_MOVE_SPEED = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LOOK_SENS  = 2'd1;

  localparam logic [15:0] MOVE_SPEED_RST = 16'd7680;
  localparam logic [15:0] LOOK_SENS_RST  = 16'd3277;

  // Move directions.
  localparam logic [1:0] DIR_FORWARD = 2'd0;
  localparam logic [1:0] DIR_BACK    = 2'd1;
  localparam logic [1:0] DIR_LEFT    = 2'd2;
  localparam logic [1:0] DIR_RIGHT   = 2'd3;

  typedef enum logic {CMD_MOVE = 1'b0, CMD_LOOK = 1'b1} cmd_t;

  typedef struct packed {
    cmd_t               kind;
    logic [1:0]         move_dir;
    logic [15:0]        delta_time;
    logic signed [15:0] mouse_dx;
    logic signed [15:0] mouse_dy;
    logic               clamp_pitch;
  } cam_item_t;

  typedef struct packed {
    logic signed [15:0] pitch_out;
    logic signed [15:0] yaw_out;
    logic signed [15:0] up_z;
    logic signed [15:0] up_y;
    logic signed [15:0] up_x;
    logic signed [15:0] front_z;
    logic signed [15:0] front_y;
    logic signed [15:0] front_x;
    logic signed [31:0] pos_z;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } cam_res_t;

  // Divisor and its reciprocal floor(2^32 / d) for the constant divider.
  // Kind 0 is the angle to radian scale, kind 1 the Taylor steps.
  function automatic logic [14:0] div_const(input logic kind, input logic [1:0] k);
    logic [14:0] d;
    d = 15'd23040;
    if (kind) begin
      case (k)
        2'd0: d = 15'd72;
        2'd1: d = 15'd42;
        2'd2: d = 15'd20;
        2'd3: d = 15'd6;
        default: d = 15'd6;
      endcase
    end
    return d;
  endfunction

  function automatic logic [31:0] div_recip(input logic kind, input logic [1:0] k);
    logic [31:0] m;
    m = 32'd186413;
    if (kind) begin
      case (k)
        2'd0: m = 32'd59652323;
        2'd1: m = 32'd102261126;
        2'd2: m = 32'd214748364;
        2'd3: m = 32'd715827882;
        default: m = 32'd715827882;
      endcase
    end
    return m;
  endfunction

endpackage

// ===== src/eacc_front.sv =====
module eacc_front import eacc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_cmd,
  input  logic [55:0] in_data,
  output logic       q_valid,
  input  logic       q_ready,
  output cam_item_t  q_item
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cam_item_t           mem_r [QueueDepth];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     count_r;
  cam_item_t           item;
  logic                push, pop;

  // Classify the word and clear the fields that its kind does not use.
  always_comb begin
    item = '0;
    item.kind = cmd_t'(in_cmd);
    if (in_cmd == CMD_LOOK) begin
      item.mouse_dx    = in_data[33:18];
      item.mouse_dy    = in_data[49:34];
      item.clamp_pitch = in_data[50];
    end else begin
      item.move_dir   = in_data[1:0];
      item.delta_time = in_data[17:2];
    end
  end

  assign in_ready = (count_r != CntW'(QueueDepth));
  assign q_valid  = (count_r != '0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(QueueDepth)) else $error("queue count overflow");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1)) else $error("push lost");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - 1'b1)) else $error("pop lost");

endmodule

// ===== src/eacc_back.sv =====
module eacc_back import eacc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] move_speed,
  input  logic [15:0] look_sens,
  input  logic        q_valid,
  output logic        q_ready,
  input  cam_item_t   q_item,
  output logic        res_valid,
  input  logic        res_ready,
  output cam_res_t    res
);

  typedef enum logic [4:0] {
    S_IDLE, S_MV_SPD, S_MV_LD, S_MV_MUL, S_MV_ACC,
    S_LK_DX, S_LK_DY, S_LK_P, S_W1, S_W2, S_W3,
    S_SN0, S_SN1, S_SN2, S_DV1, S_DV2, S_DV3, S_TSQ, S_TSQ2,
    S_TMUL, S_TMUL2, S_SFIN, S_SFIN2, S_VM, S_VW, S_DONE
  } state_t;

  state_t             state_r;
  cam_item_t          item_r;
  logic signed [65:0] prod_r;
  logic signed [31:0] pos_r [3];
  logic signed [15:0] front_r [3];
  logic signed [15:0] right_r [3];
  logic signed [15:0] up_r [3];
  logic signed [15:0] yaw_r, pitch_r;
  logic signed [15:0] sin_r [4];
  logic [31:0]        speed_r;
  logic [1:0]         idx_r;
  logic signed [24:0] w_r, b_r;
  logic               wsel_r;
  logic [1:0]         sj_r, k_r, vi_r;
  logic [13:0]        x_r;
  logic               neg_r, dkind_r;
  logic [30:0]        th_r, v_r;
  logic [31:0]        th2_r, dn_r, qd_r;

  logic signed [32:0] ma, mb;
  logic signed [65:0] sh9, sh14, sh22;
  logic signed [23:0] dd;
  logic signed [25:0] wv, wm_raw, wm;
  logic signed [13:0] wt;
  logic [13:0]        wu;
  logic signed [8:0]  wq;
  logic signed [15:0] wres;
  logic signed [16:0] sa, su;
  logic [1:0]         sq;
  logic [13:0]        sr, sx;
  logic [14:0]        dv_d;
  logic [31:0]        dv_m;
  logic [32:0]        rr, srnd_sum;
  logic [31:0]        qf;
  logic [16:0]        srnd;
  logic [15:0]        smag;
  logic signed [15:0] sval, r14, va, vb, mvec;
  logic signed [26:0] md, nd;
  logic signed [33:0] psum;
  logic signed [31:0] psat;
  logic               s_pos;

  // Rounded shifts of the shared product.
  assign sh9  = (prod_r + 66'sd256) >>> 9;
  assign sh14 = (prod_r + 66'sd8192) >>> 14;
  assign sh22 = (prod_r + 66'sd2097152) >>> 22;
  assign dd   = sh9[23:0];
  assign r14  = sh14[15:0];
  assign md   = sh22[26:0];

  // Angle wrap into [-23040, 23039]: quotient estimate by reciprocal of 45
  // after dropping ten low bits, then one correction.
  assign wv     = {w_r[24], w_r} + 26'sd23040;
  assign wt     = wv[23:10];
  assign wu     = wt + 14'd4500;
  assign wq     = $signed({1'b0, prod_r[23:16]}) - 9'sd100;
  assign wm_raw = wv - $signed(prod_r[25:0]);
  assign wm     = (wm_raw < 0) ? wm_raw + 26'sd46080 : wm_raw;
  assign wres   = 16'(wm - 26'sd23040);

  // Angle for the current sine: yaw, yaw plus a quarter turn, pitch, pitch
  // plus a quarter turn. Folded into the first quadrant.
  always_comb begin
    case (sj_r)
      2'd0: sa = 17'(yaw_r);
      2'd1: sa = 17'(yaw_r) + 17'sd11520;
      2'd2: sa = 17'(pitch_r);
      2'd3: sa = 17'(pitch_r) + 17'sd11520;
      default: sa = 17'(yaw_r);
    endcase
    su = (sa < 0) ? sa + 17'sd46080 : sa;
    if (su >= 17'sd34560) begin
      sq = 2'd3;
      sr = 14'(su - 17'sd34560);
    end else if (su >= 17'sd23040) begin
      sq = 2'd2;
      sr = 14'(su - 17'sd23040);
    end else if (su >= 17'sd11520) begin
      sq = 2'd1;
      sr = 14'(su - 17'sd11520);
    end else begin
      sq = 2'd0;
      sr = su[13:0];
    end
    sx = sq[0] ? 14'd11520 - sr : sr;
  end

  assign dv_d     = div_const(dkind_r, k_r);
  assign dv_m     = div_recip(dkind_r, k_r);
  assign rr       = {1'b0, dn_r} - {1'b0, prod_r[31:0]};
  assign qf       = (rr >= {18'd0, dv_d}) ? qd_r + 32'd1 : qd_r;
  assign srnd_sum = {1'b0, prod_r[61:30]} + 33'd32768;
  assign srnd     = srnd_sum[32:16];
  assign smag     = (srnd > 17'd16384) ? 16'd16384 : srnd[15:0];
  assign sval     = neg_r ? -$signed(smag) : $signed(smag);

  // A move goes along front for forward or back and along right otherwise.
  assign mvec = (item_r.move_dir == DIR_FORWARD || item_r.move_dir == DIR_BACK) ?
                front_r[idx_r] : right_r[idx_r];
  assign nd   = (item_r.move_dir == DIR_BACK || item_r.move_dir == DIR_LEFT) ? -md : md;
  assign psum = 34'(pos_r[idx_r]) + 34'(nd);
  assign psat = (psum > 34'sd2147483647) ? 32'sh7fffffff :
                (psum < -34'sd2147483648) ? 32'sh80000000 : psum[31:0];

  assign s_pos = (pitch_r >= -16'sd11520) && (pitch_r <= 16'sd11520);

  always_comb begin
    case (vi_r)
      2'd0: begin va = sin_r[1]; vb = sin_r[3]; end
      2'd1: begin va = sin_r[0]; vb = sin_r[3]; end
      2'd2: begin va = sin_r[1]; vb = sin_r[2]; end
      default: begin va = sin_r[0]; vb = sin_r[2]; end
    endcase
  end

  // Operand selection for the one shared multiplier.
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_MV_SPD: begin ma = {17'd0, move_speed}; mb = {17'd0, item_r.delta_time}; end
      S_MV_MUL: begin ma = 33'(mvec); mb = {1'b0, speed_r}; end
      S_LK_DX:  begin ma = 33'(item_r.mouse_dx); mb = {17'd0, look_sens}; end
      S_LK_DY:  begin ma = 33'(item_r.mouse_dy); mb = {17'd0, look_sens}; end
      S_W1:     begin ma = {19'd0, wu}; mb = 33'sd1457; end
      S_W2:     begin ma = 33'(wq); mb = 33'sd46080; end
      S_SN0:    begin ma = {19'd0, sx}; mb = 33'sd19106; end
      S_SN1:    begin ma = {19'd0, x_r}; mb = 33'sd146408; end
      S_DV1:    begin ma = {1'b0, dn_r}; mb = {1'b0, dv_m}; end
      S_DV2:    begin ma = {1'b0, prod_r[63:32]}; mb = {18'd0, dv_d}; end
      S_TSQ:    begin ma = {2'b0, th_r}; mb = {2'b0, th_r}; end
      S_TMUL:   begin ma = {1'b0, th2_r}; mb = {2'b0, v_r}; end
      S_SFIN:   begin ma = {2'b0, th_r}; mb = {2'b0, v_r}; end
      S_VM:     begin ma = 33'(va); mb = 33'(vb); end
      default:  begin ma = '0; mb = '0; end
    endcase
  end

  assign q_ready   = (state_r == S_IDLE);
  assign res_valid = (state_r == S_DONE);

  always_comb begin
    res.pos_x     = pos_r[0];
    res.pos_y     = pos_r[1];
    res.pos_z     = pos_r[2];
    res.front_x   = front_r[0];
    res.front_y   = front_r[1];
    res.front_z   = front_r[2];
    res.up_x      = up_r[0];
    res.up_y      = up_r[1];
    res.up_z      = up_r[2];
    res.yaw_out   = yaw_r;
    res.pitch_out = pitch_r;
  end

  always_ff @(posedge clk) begin
    prod_r <= ma * mb;
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pos_r[0]   <= 32'sd0;
      pos_r[1]   <= 32'sd327680;
      pos_r[2]   <= 32'sd524288;
      yaw_r      <= -16'sd11520;
      pitch_r    <= -16'sd640;
      front_r[0] <= 16'sd0;
      front_r[1] <= -16'sd1428;
      front_r[2] <= -16'sd16322;
      right_r[0] <= 16'sd16384;
      right_r[1] <= 16'sd0;
      right_r[2] <= 16'sd0;
      up_r[0]    <= 16'sd0;
      up_r[1]    <= 16'sd16322;
      up_r[2]    <= -16'sd1428;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            item_r  <= q_item;
            state_r <= (q_item.kind == CMD_LOOK) ? S_LK_DX : S_MV_SPD;
          end
        end
        S_MV_SPD: state_r <= S_MV_LD;
        S_MV_LD: begin
          speed_r <= prod_r[31:0];
          idx_r   <= 2'd0;
          state_r <= S_MV_MUL;
        end
        S_MV_MUL: state_r <= S_MV_ACC;
        S_MV_ACC: begin
          pos_r[idx_r] <= psat;
          idx_r        <= idx_r + 2'd1;
          state_r      <= (idx_r == 2'd2) ? S_DONE : S_MV_MUL;
        end
        S_LK_DX: state_r <= S_LK_DY;
        S_LK_DY: begin
          w_r     <= 25'(yaw_r) + 25'(dd);
          wsel_r  <= 1'b0;
          state_r <= S_LK_P;
        end
        S_LK_P: begin
          b_r     <= 25'(pitch_r) + 25'(dd);
          state_r <= S_W1;
        end
        S_W1: state_r <= S_W2;
        S_W2: state_r <= S_W3;
        S_W3: begin
          sj_r <= 2'd0;
          if (!wsel_r) begin
            yaw_r <= wres;
            if (item_r.clamp_pitch) begin
              if (b_r > 25'sd11392) begin
                pitch_r <= 16'sd11392;
              end else if (b_r < -25'sd11392) begin
                pitch_r <= -16'sd11392;
              end else begin
                pitch_r <= b_r[15:0];
              end
              state_r <= S_SN0;
            end else begin
              w_r     <= b_r;
              wsel_r  <= 1'b1;
              state_r <= S_W1;
            end
          end else begin
            pitch_r <= wres;
            state_r <= S_SN0;
          end
        end
        S_SN0: begin
          x_r     <= sx;
          neg_r   <= sq[1];
          state_r <= S_SN1;
        end
        S_SN1: begin
          dn_r    <= prod_r[31:0] + 32'd11520;
          state_r <= S_SN2;
        end
        S_SN2: begin
          th_r    <= prod_r[30:0];
          dkind_r <= 1'b0;
          state_r <= S_DV1;
        end
        S_DV1: state_r <= S_DV2;
        S_DV2: begin
          qd_r    <= prod_r[63:32];
          state_r <= S_DV3;
        end
        S_DV3: begin
          if (!dkind_r) begin
            th_r    <= th_r + qf[30:0];
            state_r <= S_TSQ;
          end else begin
            v_r     <= 31'h40000000 - qf[30:0];
            k_r     <= k_r + 2'd1;
            state_r <= (k_r == 2'd3) ? S_SFIN : S_TMUL;
          end
        end
        S_TSQ: state_r <= S_TSQ2;
        S_TSQ2: begin
          th2_r   <= prod_r[61:30];
          v_r     <= 31'h40000000;
          k_r     <= 2'd0;
          dkind_r <= 1'b1;
          state_r <= S_TMUL;
        end
        S_TMUL: state_r <= S_TMUL2;
        S_TMUL2: begin
          dn_r    <= prod_r[61:30];
          state_r <= S_DV1;
        end
        S_SFIN: state_r <= S_SFIN2;
        S_SFIN2: begin
          sin_r[sj_r] <= sval;
          sj_r        <= sj_r + 2'd1;
          vi_r        <= 2'd0;
          state_r     <= (sj_r == 2'd3) ? S_VM : S_SN0;
        end
        S_VM: state_r <= S_VW;
        S_VW: begin
          case (vi_r)
            2'd0: front_r[0] <= r14;
            2'd1: front_r[2] <= r14;
            2'd2: up_r[0] <= s_pos ? -r14 : r14;
            default: begin
              up_r[2]    <= s_pos ? -r14 : r14;
              front_r[1] <= sin_r[2];
              up_r[1]    <= s_pos ? sin_r[3] : -sin_r[3];
              right_r[0] <= s_pos ? -sin_r[0] : sin_r[0];
              right_r[1] <= 16'sd0;
              right_r[2] <= s_pos ? sin_r[1] : -sin_r[1];
            end
          endcase
          vi_r    <= vi_r + 2'd1;
          state_r <= (vi_r == 2'd3) ? S_DONE : S_VM;
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (yaw_r >= -16'sd23040 && yaw_r <= 16'sd23039))
    else $error("yaw out of range");
  a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (pitch_r >= -16'sd23040 && pitch_r <= 16'sd23039))
    else $error("pitch out of range");
  a_unit_y: assert property (@(posedge clk) disable iff (!rst_n)
    (front_r[1] >= -16'sd16384 && front_r[1] <= 16'sd16384))
    else $error("front y beyond unit");
  a_done_release: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> (state_r == S_IDLE)) else $error("result not released");

endmodule

// ===== src/euler_angle_camera_controller.sv =====
// A move word computes its speed product, then one multiply and accumulate per axis.
// A look word scales both mouse deltas, wraps the angles and evaluates four sines on the
// shared multiplier, which takes most of its time; pitch clamping skips the pitch wrap.
// The sequencer takes one word at a time and no new one until its result is released;
// a queue of QueueDepth words in front of it keeps accepting meanwhile.
// Reset (rst_n low, synchronous) restores the camera pose and both config registers.
module euler_angle_camera_controller import eacc_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  // bit 0: command
  input  logic               in_tuser,
  // move_dir [1:0], delta_time [17:2], mouse_dx [33:18], mouse_dy [49:34],
  // clamp_pitch [50], zero fill above
  input  logic [55:0]        in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  // pos_x, pos_y, pos_z (32 bits each), then front_x, front_y, front_z,
  // up_x, up_y, up_z, yaw_out, pitch_out (16 bits each), from bit 0 up
  output logic [223:0]       out_tdata,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0] move_speed_r, look_sens_r;
  logic        q_valid, q_ready, res_valid, res_ready;
  cam_item_t   q_item;
  cam_res_t    res, out_r;
  logic        out_valid_r;

  // Configuration is always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_speed_r <= MOVE_SPEED_RST;
      look_sens_r  <= LOOK_SENS_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_MOVE_SPEED) begin
        move_speed_r <= cfg_data;
      end else if (cfg_index == REG_LOOK_SENS) begin
        look_sens_r <= cfg_data;
      end
    end
  end

  // The front end classifies incoming words and queues them.
  eacc_front #(.QueueDepth(QueueDepth)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_cmd   (in_tuser),
    .in_data  (in_tdata),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  // The back end holds the camera state and runs one word at a time.
  eacc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .move_speed (move_speed_r),
    .look_sens  (look_sens_r),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // Output register: the sequencer is released as soon as its result is captured.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

endmodule
